// ===== rtl/core/thci_pkg.sv =====
package thci_pkg;

    // Table geometry
    localparam int TABLE_DEPTH_DEF = 1024;
    localparam int COUNT_MIN       = 4;
    localparam int IDX_W           = 11;

    // Datapath geometry
    localparam int WORD_W = 32;
    localparam int LIMBS  = 5;
    localparam int WIDE_W = LIMBS * WORD_W;
    localparam int REM_W  = 3 * WORD_W + 2;
    localparam int BIT_W  = $clog2(WIDE_W);

    localparam logic signed [WORD_W-1:0] WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
    localparam logic signed [WORD_W-1:0] WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

    typedef enum logic {
        OP_LOAD  = 1'b0,
        OP_QUERY = 1'b1
    } thci_op_t;

    typedef struct packed {
        thci_op_t                  op;
        logic [IDX_W-1:0]          entry_index;
        logic signed [WORD_W-1:0]  table_x;
        logic signed [WORD_W-1:0]  table_y;
        logic signed [WORD_W-1:0]  query_x;
        logic [IDX_W-1:0]          start_hint;
    } thci_in_t;

    typedef struct packed {
        logic signed [WORD_W-1:0]  interp_value;
        logic [IDX_W-1:0]          bracket_index;
    } thci_out_t;

endpackage

// ===== rtl/core/thci_ram.sv =====
module thci_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write one word, read one word registered
    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

// ===== rtl/core/table_hunt_cubic_interpolator.sv =====
// Monotone table lookup with four-point cubic Lagrange interpolation.
// Input channel s_valid/s_ready/s_data carries load words (one table entry each)
// and query words (point plus start hint). A load is written in the cycle it is
// taken and returns nothing; a query returns one word on m_valid/m_ready/m_data:
// the interpolated ordinate in signed Q16.16, saturated, and the lower bracket.
// cfg_valid/cfg_ready/cfg_data writes the entry count, clamped to 4..TABLE_DEPTH.
// A query first hunts outward from the hint and bisects to find the bracket, then
// works four polynomial terms. The term work is done by the limb-serial 32x32
// multiplier (six wide products per term) and the restoring divider, which makes
// one quotient bit of 160 a cycle. One query is worked at a time; s_ready is low
// while it runs. The result sits in an output register, so the next word is taken
// while it waits; a finished query holds in the sequencer until m_ready frees
// that register. Reset clears the sequencer, drops any pending result and sets
// the count to 4; table contents are not cleared and must be loaded before use.
module table_hunt_cubic_interpolator #(
    parameter int TABLE_DEPTH = thci_pkg::TABLE_DEPTH_DEF
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       s_valid,
    output logic                       s_ready,
    input  thci_pkg::thci_in_t         s_data,
    output logic                       m_valid,
    input  logic                       m_ready,
    output thci_pkg::thci_out_t        m_data,
    input  logic                       cfg_valid,
    output logic                       cfg_ready,
    input  logic [thci_pkg::IDX_W-1:0] cfg_data
);

    import thci_pkg::*;

    localparam int AW = $clog2(TABLE_DEPTH);
    localparam int CW = $clog2(TABLE_DEPTH + 1);
    localparam int IW = CW + 2;

    typedef enum logic [4:0] {
        ST_IDLE, ST_RD_FIRST, ST_RD_LAST, ST_ASC,
        ST_HINT_RD, ST_HINT_CMP, ST_UP_RD, ST_UP_CMP, ST_DN_RD, ST_DN_CMP,
        ST_BIS_CHK, ST_BIS_RD, ST_BIS_CMP,
        ST_WIN, ST_NODE_RD, ST_NODE_ST, ST_NUDGE,
        ST_T_INIT, ST_T_FAC, ST_MUL_GO, ST_MUL_P, ST_MUL_A, ST_MUL_END,
        ST_DIV_INIT, ST_DIV, ST_RND, ST_ACC, ST_NEXT_TERM, ST_OUT
    } state_t;

    state_t                    state_reg, state_next;
    logic [CW-1:0]             count_reg, count_next;
    logic signed [WORD_W:0]    xq_reg, xq_next;
    logic [IDX_W-1:0]          hint_reg, hint_next;
    logic signed [WORD_W-1:0]  x1_reg, x1_next;
    logic                      asc_reg, asc_next;
    logic signed [IW-1:0]      lo_reg, lo_next;
    logic signed [IW-1:0]      hi_reg, hi_next;
    logic signed [IW-1:0]      inc_reg, inc_next;
    logic signed [IW-1:0]      mid_reg, mid_next;
    logic signed [IW-1:0]      k_reg, k_next;
    logic [1:0]                node_reg, node_next;
    logic signed [WORD_W-1:0]  nx_reg [4];
    logic signed [WORD_W-1:0]  nx_next [4];
    logic signed [WORD_W-1:0]  ny_reg [4];
    logic signed [WORD_W-1:0]  ny_next [4];
    logic signed [WORD_W-1:0]  xi_reg, xi_next;
    logic [1:0]                term_reg, term_next;
    logic [1:0]                fac_reg, fac_next;
    logic [WIDE_W-1:0]         num_reg, num_next;
    logic [WIDE_W-1:0]         den_reg, den_next;
    logic                      neg_reg, neg_next;
    logic [WORD_W:0]           mdn_reg, mdn_next;
    logic [WORD_W:0]           mdd_reg, mdd_next;
    logic                      dphase_reg, dphase_next;
    logic [2:0]                limb_reg, limb_next;
    logic [2*WORD_W-1:0]       prod_reg, prod_next;
    logic [WORD_W-1:0]         carry_reg, carry_next;
    logic [REM_W-1:0]          rem_reg, rem_next;
    logic [WIDE_W-1:0]         q_reg, q_next;
    logic [BIT_W-1:0]          bit_reg, bit_next;
    logic [WIDE_W-1:0]         acc_reg, acc_next;
    logic                      out_valid_reg, out_valid_next;
    thci_out_t                 out_reg, out_next;

    logic                      ram_we;
    logic [AW-1:0]             ram_waddr;
    logic [2*WORD_W-1:0]       ram_wdata;
    logic [AW-1:0]             ram_raddr;
    logic [2*WORD_W-1:0]       ram_rdata;
    logic signed [IW-1:0]      rd_idx;
    logic signed [WORD_W-1:0]  rd_x;
    logic signed [WORD_W-1:0]  rd_y;
    logic signed [WORD_W:0]    rd_x33;
    logic signed [IW-1:0]      n_s;

    assign rd_x   = ram_rdata[2*WORD_W-1:WORD_W];
    assign rd_y   = ram_rdata[WORD_W-1:0];
    assign rd_x33 = {rd_x[WORD_W-1], rd_x};
    assign n_s    = $signed({2'b00, count_reg});

    assign ram_raddr = AW'(rd_idx - IW'(1));
    assign s_ready   = (state_reg == ST_IDLE);
    assign cfg_ready = 1'b1;
    assign m_valid   = out_valid_reg;
    assign m_data    = out_reg;

    thci_ram #(
        .WIDTH (2 * WORD_W),
        .DEPTH (TABLE_DEPTH)
    ) u_table (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    // Sequencer next-state and datapath
    always_comb begin
        logic signed [WORD_W+1:0] dn;
        logic signed [WORD_W:0]   dd;
        logic signed [WORD_W:0]   y33;
        logic signed [IW-1:0]     cand;
        logic [WORD_W:0]          mul_m;
        logic [WIDE_W-1:0]        wsel;
        logic [2*WORD_W-1:0]      tsum;
        logic [REM_W-1:0]         rtry;
        logic                     ge;
        logic [31:0]              cfg_ext;

        state_next     = state_reg;
        count_next     = count_reg;
        xq_next        = xq_reg;
        hint_next      = hint_reg;
        x1_next        = x1_reg;
        asc_next       = asc_reg;
        lo_next        = lo_reg;
        hi_next        = hi_reg;
        inc_next       = inc_reg;
        mid_next       = mid_reg;
        k_next         = k_reg;
        node_next      = node_reg;
        nx_next        = nx_reg;
        ny_next        = ny_reg;
        xi_next        = xi_reg;
        term_next      = term_reg;
        fac_next       = fac_reg;
        num_next       = num_reg;
        den_next       = den_reg;
        neg_next       = neg_reg;
        mdn_next       = mdn_reg;
        mdd_next       = mdd_reg;
        dphase_next    = dphase_reg;
        limb_next      = limb_reg;
        prod_next      = prod_reg;
        carry_next     = carry_reg;
        rem_next       = rem_reg;
        q_next         = q_reg;
        bit_next       = bit_reg;
        acc_next       = acc_reg;
        out_valid_next = out_valid_reg;
        out_next       = out_reg;
        ram_we         = 1'b0;
        ram_waddr      = AW'(s_data.entry_index - IDX_W'(1));
        ram_wdata      = {s_data.table_x, s_data.table_y};
        rd_idx         = lo_reg;
        dn             = '0;
        dd             = '0;
        y33            = '0;
        cand           = '0;
        mul_m          = dphase_reg ? mdd_reg : mdn_reg;
        wsel           = dphase_reg ? den_reg : num_reg;
        tsum           = '0;
        rtry           = '0;
        ge             = 1'b0;
        cfg_ext        = 32'(cfg_data);

        // Clamp and hold the entry count
        if (cfg_valid) begin
            if (cfg_ext < 32'(COUNT_MIN)) begin
                count_next = CW'(COUNT_MIN);
            end else if (cfg_ext > 32'(TABLE_DEPTH)) begin
                count_next = CW'(TABLE_DEPTH);
            end else begin
                count_next = CW'(cfg_data);
            end
        end

        // Drop the result word once taken
        if (out_valid_reg && m_ready) begin
            out_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    if (s_data.op == OP_QUERY) begin
                        xq_next    = {s_data.query_x[WORD_W-1], s_data.query_x};
                        hint_next  = s_data.start_hint;
                        state_next = ST_RD_FIRST;
                    end else if (s_data.entry_index != '0 &&
                                 32'(s_data.entry_index) <= 32'(TABLE_DEPTH)) begin
                        ram_we = 1'b1;
                    end
                end
            end
            ST_RD_FIRST: begin
                rd_idx     = IW'(1);
                state_next = ST_RD_LAST;
            end
            ST_RD_LAST: begin
                rd_idx     = n_s;
                x1_next    = rd_x;
                state_next = ST_ASC;
            end
            ST_ASC: begin
                asc_next = rd_x > x1_reg;
                inc_next = IW'(1);
                if (hint_reg == '0 || 32'(hint_reg) > 32'(count_reg)) begin
                    lo_next    = '0;
                    hi_next    = n_s + IW'(1);
                    state_next = ST_BIS_CHK;
                end else begin
                    lo_next    = $signed(IW'(hint_reg));
                    state_next = ST_HINT_RD;
                end
            end
            ST_HINT_RD: begin
                rd_idx     = lo_reg;
                state_next = ST_HINT_CMP;
            end
            ST_HINT_CMP: begin
                if ((xq_reg >= rd_x33) == asc_reg) begin
                    if (lo_reg == n_s) begin
                        state_next = ST_WIN;
                    end else begin
                        hi_next    = lo_reg + IW'(1);
                        state_next = ST_UP_RD;
                    end
                end else begin
                    if (lo_reg == IW'(1)) begin
                        lo_next    = '0;
                        state_next = ST_WIN;
                    end else begin
                        hi_next    = lo_reg;
                        lo_next    = lo_reg - IW'(1);
                        state_next = ST_DN_RD;
                    end
                end
            end
            ST_UP_RD: begin
                rd_idx     = hi_reg;
                state_next = ST_UP_CMP;
            end
            // Hunt upward with doubling steps
            ST_UP_CMP: begin
                if ((xq_reg >= rd_x33) == asc_reg) begin
                    lo_next  = hi_reg;
                    inc_next = inc_reg <<< 1;
                    cand     = hi_reg + (inc_reg <<< 1);
                    if (cand > n_s) begin
                        hi_next    = n_s + IW'(1);
                        state_next = ST_BIS_CHK;
                    end else begin
                        hi_next    = cand;
                        state_next = ST_UP_RD;
                    end
                end else begin
                    state_next = ST_BIS_CHK;
                end
            end
            ST_DN_RD: begin
                rd_idx     = lo_reg;
                state_next = ST_DN_CMP;
            end
            // Hunt downward with doubling steps
            ST_DN_CMP: begin
                if ((xq_reg < rd_x33) == asc_reg) begin
                    hi_next  = lo_reg;
                    inc_next = inc_reg <<< 1;
                    cand     = lo_reg - (inc_reg <<< 1);
                    if (cand < IW'(1)) begin
                        lo_next    = '0;
                        state_next = ST_BIS_CHK;
                    end else begin
                        lo_next    = cand;
                        state_next = ST_DN_RD;
                    end
                end else begin
                    state_next = ST_BIS_CHK;
                end
            end
            ST_BIS_CHK: begin
                if (hi_reg - lo_reg == IW'(1)) begin
                    state_next = ST_WIN;
                end else begin
                    mid_next   = (hi_reg + lo_reg) >>> 1;
                    state_next = ST_BIS_RD;
                end
            end
            ST_BIS_RD: begin
                rd_idx     = mid_reg;
                state_next = ST_BIS_CMP;
            end
            ST_BIS_CMP: begin
                if ((xq_reg > rd_x33) == asc_reg) begin
                    lo_next = mid_reg;
                end else begin
                    hi_next = mid_reg;
                end
                state_next = ST_BIS_CHK;
            end
            // Clamp the four-node window inside the table
            ST_WIN: begin
                cand = lo_reg - IW'(1);
                if (cand < IW'(1)) begin
                    cand = IW'(1);
                end
                if (cand > n_s - IW'(3)) begin
                    cand = n_s - IW'(3);
                end
                k_next     = cand;
                node_next  = '0;
                state_next = ST_NODE_RD;
            end
            ST_NODE_RD: begin
                rd_idx     = k_reg + IW'(node_reg);
                state_next = ST_NODE_ST;
            end
            ST_NODE_ST: begin
                nx_next[node_reg] = rd_x;
                ny_next[node_reg] = rd_y;
                node_next         = node_reg + 2'd1;
                state_next        = (node_reg == 2'd3) ? ST_NUDGE : ST_NODE_RD;
            end
            // Move the point off a node by one LSB
            ST_NUDGE: begin
                if (xq_reg == {nx_reg[0][WORD_W-1], nx_reg[0]} ||
                    xq_reg == {nx_reg[1][WORD_W-1], nx_reg[1]} ||
                    xq_reg == {nx_reg[2][WORD_W-1], nx_reg[2]} ||
                    xq_reg == {nx_reg[3][WORD_W-1], nx_reg[3]}) begin
                    xq_next = xq_reg + (WORD_W+1)'(1);
                end
                acc_next   = '0;
                term_next  = '0;
                state_next = ST_T_INIT;
            end
            // Current term's node sits at slot zero
            ST_T_INIT: begin
                y33        = {ny_reg[0][WORD_W-1], ny_reg[0]};
                y33        = y33[WORD_W] ? -y33 : y33;
                num_next   = WIDE_W'(y33[WORD_W-1:0]);
                den_next   = WIDE_W'(1);
                neg_next   = ny_reg[0][WORD_W-1];
                xi_next    = nx_reg[0];
                fac_next   = '0;
                state_next = ST_T_FAC;
            end
            ST_T_FAC: begin
                if (fac_reg == '0) begin
                    // skip the term's own node and advance the ring
                    nx_next    = '{nx_reg[1], nx_reg[2], nx_reg[3], nx_reg[0]};
                    fac_next   = 2'd1;
                end else begin
                    dn          = (WORD_W+2)'(xq_reg) - (WORD_W+2)'(nx_reg[0]);
                    dd          = (WORD_W+1)'(xi_reg) - (WORD_W+1)'(nx_reg[0]);
                    mdn_next    = dn[WORD_W+1] ? (WORD_W+1)'(-dn) : (WORD_W+1)'(dn);
                    mdd_next    = dd[WORD_W] ? (WORD_W+1)'(-dd) : (WORD_W+1)'(dd);
                    neg_next    = neg_reg ^ dn[WORD_W+1] ^ dd[WORD_W];
                    dphase_next = 1'b0;
                    state_next  = ST_MUL_GO;
                end
            end
            // Start one wide product by a 33-bit factor
            ST_MUL_GO: begin
                if (mul_m[WORD_W]) begin
                    if (dphase_reg) begin
                        den_next = den_reg << WORD_W;
                    end else begin
                        num_next = num_reg << WORD_W;
                    end
                    state_next = ST_MUL_END;
                end else begin
                    limb_next  = '0;
                    carry_next = '0;
                    state_next = ST_MUL_P;
                end
            end
            ST_MUL_P: begin
                prod_next  = wsel[limb_reg*WORD_W +: WORD_W] * mul_m[WORD_W-1:0];
                state_next = ST_MUL_A;
            end
            ST_MUL_A: begin
                tsum = prod_reg + (2*WORD_W)'(carry_reg);
                wsel[limb_reg*WORD_W +: WORD_W] = tsum[WORD_W-1:0];
                if (dphase_reg) begin
                    den_next = wsel;
                end else begin
                    num_next = wsel;
                end
                carry_next = tsum[2*WORD_W-1:WORD_W];
                limb_next  = limb_reg + 3'd1;
                state_next = (limb_reg == 3'(LIMBS - 1)) ? ST_MUL_END : ST_MUL_P;
            end
            ST_MUL_END: begin
                if (!dphase_reg) begin
                    dphase_next = 1'b1;
                    state_next  = ST_MUL_GO;
                end else begin
                    nx_next  = '{nx_reg[1], nx_reg[2], nx_reg[3], nx_reg[0]};
                    fac_next = fac_reg + 2'd1;
                    state_next = (fac_reg == 2'd3) ? ST_DIV_INIT : ST_T_FAC;
                end
            end
            ST_DIV_INIT: begin
                rem_next = '0;
                q_next   = '0;
                bit_next = '0;
                state_next = (den_reg == '0) ? ST_NEXT_TERM : ST_DIV;
            end
            // Restoring division, one quotient bit per cycle
            ST_DIV: begin
                rtry     = {rem_reg[REM_W-2:0], num_reg[WIDE_W-1]};
                ge       = WIDE_W'(rtry) >= den_reg;
                rem_next = ge ? rtry - REM_W'(den_reg) : rtry;
                q_next   = {q_reg[WIDE_W-2:0], ge};
                num_next = num_reg << 1;
                bit_next = bit_reg + BIT_W'(1);
                if (bit_reg == BIT_W'(WIDE_W - 1)) begin
                    state_next = ST_RND;
                end
            end
            // Round to nearest, ties away from zero
            ST_RND: begin
                if (WIDE_W'({rem_reg, 1'b0}) >= den_reg) begin
                    q_next = q_reg + WIDE_W'(1);
                end
                state_next = ST_ACC;
            end
            ST_ACC: begin
                acc_next   = neg_reg ? acc_reg - q_reg : acc_reg + q_reg;
                state_next = ST_NEXT_TERM;
            end
            ST_NEXT_TERM: begin
                nx_next   = '{nx_reg[1], nx_reg[2], nx_reg[3], nx_reg[0]};
                ny_next   = '{ny_reg[1], ny_reg[2], ny_reg[3], ny_reg[0]};
                term_next = term_reg + 2'd1;
                state_next = (term_reg == 2'd3) ? ST_OUT : ST_T_INIT;
            end
            // Saturate and hand the word to the output register
            ST_OUT: begin
                if (!out_valid_reg || m_ready) begin
                    out_valid_next = 1'b1;
                    if (!acc_reg[WIDE_W-1]) begin
                        out_next.interp_value = (acc_reg[WIDE_W-2:WORD_W-1] == '0)
                            ? $signed(acc_reg[WORD_W-1:0]) : WORD_MAX;
                    end else begin
                        out_next.interp_value = (&acc_reg[WIDE_W-2:WORD_W-1])
                            ? $signed(acc_reg[WORD_W-1:0]) : WORD_MIN;
                    end
                    out_next.bracket_index = IDX_W'(lo_reg);
                    state_next = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Hold state and registered outputs
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg     <= ST_IDLE;
            count_reg     <= CW'(COUNT_MIN);
            out_valid_reg <= 1'b0;
        end else begin
            state_reg     <= state_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
        xq_reg     <= xq_next;
        hint_reg   <= hint_next;
        x1_reg     <= x1_next;
        asc_reg    <= asc_next;
        lo_reg     <= lo_next;
        hi_reg     <= hi_next;
        inc_reg    <= inc_next;
        mid_reg    <= mid_next;
        k_reg      <= k_next;
        node_reg   <= node_next;
        nx_reg     <= nx_next;
        ny_reg     <= ny_next;
        xi_reg     <= xi_next;
        term_reg   <= term_next;
        fac_reg    <= fac_next;
        num_reg    <= num_next;
        den_reg    <= den_next;
        neg_reg    <= neg_next;
        mdn_reg    <= mdn_next;
        mdd_reg    <= mdd_next;
        dphase_reg <= dphase_next;
        limb_reg   <= limb_next;
        prod_reg   <= prod_next;
        carry_reg  <= carry_next;
        rem_reg    <= rem_next;
        q_reg      <= q_next;
        bit_reg    <= bit_next;
        acc_reg    <= acc_next;
        out_reg    <= out_next;
    end

endmodule

// ===== verif/table_hunt_cubic_interpolator_tb.sv =====
`timescale 1ns / 100ps

module table_hunt_cubic_interpolator_tb;
    import thci_pkg::*;

    localparam longint X_MIN = -64'sd2147483648;
    localparam longint X_MAX = 64'sd2147483647;
    localparam int DEPTH = TABLE_DEPTH_DEF;

    logic             aclk      = 1'b0;
    logic             aresetn   = 1'b0;
    logic             s_valid   = 1'b0;
    logic             s_ready;
    thci_in_t         s_data    = '0;
    logic             m_valid;
    logic             m_ready   = 1'b0;
    thci_out_t        m_data;
    logic             cfg_valid = 1'b0;
    logic             cfg_ready;
    logic [IDX_W-1:0] cfg_data  = '0;

    // Words waiting to go in, and answers waiting to come out
    thci_in_t  words_to_send[$];
    thci_out_t expected_answers[$];

    // Shadow of the block's table and entry count
    logic signed [WORD_W-1:0] tbl_x_mem[1:DEPTH];
    logic signed [WORD_W-1:0] tbl_y_mem[1:DEPTH];
    int                       table_count = COUNT_MIN;

    // Table contents being built for the current phase
    longint gen_x[1:DEPTH];
    longint gen_y[1:DEPTH];

    int  mismatches    = 0;
    int  items_queued  = 0;
    int  answers_seen  = 0;
    int  send_gap      = 0;
    bit  send_burst    = 1'b0;
    int  recv_hold     = 0;
    bit  long_hold_done = 1'b0;

    always #1 aclk = ~aclk;

    table_hunt_cubic_interpolator u_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data)
    );

    task automatic report_mismatch(string what, longint got, longint want);
        $display("MISMATCH %s: got %0d, expected %0d at %0t", what, got, want, $realtime);
        mismatches++;
    endtask

    function automatic logic [63:0] magnitude(longint v);
        return (v < 0) ? -v : v;
    endfunction

    // Hunt outward from the hint, then bisect to the lower bracket
    function automatic int locate_bracket(longint x, int hint);
        int n, lo, hi, inc, mid;
        bit asc;
        n   = table_count;
        asc = tbl_x_mem[n] > tbl_x_mem[1];
        lo  = 0;
        hi  = n + 1;
        if (hint != 0 && hint <= n) begin
            lo  = hint;
            inc = 1;
            if ((x >= tbl_x_mem[lo]) == asc) begin
                if (lo == n) return n;
                hi = lo + 1;
                while ((x >= tbl_x_mem[hi]) == asc) begin
                    lo  = hi;
                    inc = inc + inc;
                    hi  = lo + inc;
                    if (hi > n) begin
                        hi = n + 1;
                        break;
                    end
                end
            end else begin
                if (lo == 1) return 0;
                hi = lo;
                lo = lo - 1;
                while ((x < tbl_x_mem[lo]) == asc) begin
                    hi  = lo;
                    inc = inc + inc;
                    lo  = hi - inc;
                    if (lo < 1) begin
                        lo = 0;
                        break;
                    end
                end
            end
        end
        while (hi - lo != 1) begin
            mid = (hi + lo) >> 1;
            if ((x > tbl_x_mem[mid]) == asc) lo = mid;
            else hi = mid;
        end
        return lo;
    endfunction

    // Cubic Lagrange value over the clamped four-node window, exact then rounded
    function automatic thci_out_t interpolate(thci_in_t w);
        thci_out_t    res;
        longint       xq, dn, dd;
        longint       nx[4];
        longint       ny[4];
        int           lo, k, i, j;
        bit           neg;
        logic [159:0] num, den, quo, rem, acc;
        xq = longint'($signed(w.query_x));
        lo = locate_bracket(xq, int'(w.start_hint));
        k  = lo - 1;
        if (k < 1) k = 1;
        if (k > table_count - 3) k = table_count - 3;
        for (i = 0; i < 4; i++) begin
            nx[i] = longint'(tbl_x_mem[k + i]);
            ny[i] = longint'(tbl_y_mem[k + i]);
        end
        // nudge the point off a node
        if (xq == nx[0] || xq == nx[1] || xq == nx[2] || xq == nx[3]) xq = xq + 1;
        acc = '0;
        for (i = 0; i < 4; i++) begin
            neg = ny[i] < 0;
            num = 160'(magnitude(ny[i]));
            den = 160'd1;
            for (j = 0; j < 4; j++) begin
                if (j != i) begin
                    dn  = xq - nx[j];
                    dd  = nx[i] - nx[j];
                    num = num * 160'(magnitude(dn));
                    den = den * 160'(magnitude(dd));
                    if (dn < 0) neg = !neg;
                    if (dd < 0) neg = !neg;
                end
            end
            // repeated nodes drop the term
            if (den != '0) begin
                quo = num / den;
                rem = num % den;
                if ((rem << 1) >= den) quo = quo + 160'd1;
                acc = neg ? acc - quo : acc + quo;
            end
        end
        if (!acc[159]) res.interp_value = (acc[159:31] == '0) ? acc[31:0] : WORD_MAX;
        else res.interp_value = (&acc[159:31]) ? acc[31:0] : WORD_MIN;
        res.bracket_index = lo[IDX_W-1:0];
        return res;
    endfunction

    // Driver: present queued words, predict on acceptance, insert random gaps
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else begin
            if (s_valid && s_ready) begin
                if (s_data.op == OP_QUERY) begin
                    expected_answers.push_back(interpolate(s_data));
                end else if (s_data.entry_index >= 1 && s_data.entry_index <= DEPTH) begin
                    tbl_x_mem[s_data.entry_index] = s_data.table_x;
                    tbl_y_mem[s_data.entry_index] = s_data.table_y;
                end
            end
            if (!s_valid || s_ready) begin
                if (send_gap > 0) begin
                    send_gap <= send_gap - 1;
                    s_valid  <= 1'b0;
                end else if (words_to_send.size() != 0) begin
                    s_data  <= words_to_send.pop_front();
                    s_valid <= 1'b1;
                    if ($urandom_range(0, 99) == 0) send_burst = !send_burst;
                    case ($urandom_range(0, 99)) inside
                        [0:59]:  send_gap <= 0;
                        [60:89]: send_gap <= send_burst ? 0 : $urandom_range(1, 3);
                        [90:96]: send_gap <= send_burst ? 0 : $urandom_range(4, 10);
                        default: send_gap <= send_burst ? 0 : $urandom_range(30, 200);
                    endcase
                end else begin
                    s_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: check each answer against the oldest prediction, stall at random
    always @(posedge aclk) begin
        thci_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else begin
            if (m_valid && m_ready) begin
                answers_seen++;
                if (expected_answers.size() == 0) begin
                    report_mismatch("unexpected answer, bracket", m_data.bracket_index, -1);
                end else begin
                    want = expected_answers.pop_front();
                    if (m_data.interp_value !== want.interp_value)
                        report_mismatch("interp_value", $signed(m_data.interp_value),
                                        $signed(want.interp_value));
                    if (m_data.bracket_index !== want.bracket_index)
                        report_mismatch("bracket_index", m_data.bracket_index,
                                        want.bracket_index);
                end
            end
            if (recv_hold > 0) begin
                recv_hold <= recv_hold - 1;
                m_ready   <= 1'b0;
            end else if (!long_hold_done && m_valid && answers_seen >= 10 &&
                         words_to_send.size() > 4) begin
                // hold off long enough for the block to back up into its input
                long_hold_done <= 1'b1;
                recv_hold      <= 3000;
                m_ready        <= 1'b0;
            end else begin
                case ($urandom_range(0, 99)) inside
                    [0:2]:   begin
                        recv_hold <= $urandom_range(20, 200);
                        m_ready   <= 1'b0;
                    end
                    [3:19]:  m_ready <= 1'b0;
                    default: m_ready <= 1'b1;
                endcase
            end
        end
    end

    task automatic push_load(int idx, longint x, longint y);
        thci_in_t w;
        w.op          = OP_LOAD;
        w.entry_index = idx[IDX_W-1:0];
        w.table_x     = x[31:0];
        w.table_y     = y[31:0];
        w.query_x     = $urandom;
        w.start_hint  = $urandom;
        words_to_send.push_back(w);
        if (idx >= 1 && idx <= DEPTH) items_queued++;
    endtask

    task automatic push_query(longint x, int hint);
        thci_in_t w;
        w.op          = OP_QUERY;
        w.entry_index = $urandom;
        w.table_x     = $urandom;
        w.table_y     = $urandom;
        w.query_x     = x[31:0];
        w.start_hint  = hint[IDX_W-1:0];
        words_to_send.push_back(w);
        items_queued++;
    endtask

    // Wait until every word is in and every answer is out, then let the block settle
    task automatic drain();
        while (words_to_send.size() != 0 || s_valid || expected_answers.size() != 0)
            @(posedge aclk);
        repeat (20) @(posedge aclk);
    endtask

    task automatic write_count(int raw);
        int v;
        drain();
        @(posedge aclk);
        cfg_valid <= 1'b1;
        cfg_data  <= raw[IDX_W-1:0];
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        v = raw & 32'h7FF;
        if (v < COUNT_MIN) v = COUNT_MIN;
        if (v > DEPTH) v = DEPTH;
        table_count = v;
    endtask

    // One setting of the count: fill a fresh table, then query it
    task automatic run_phase(int raw, int n_queries);
        int     n, shape, i, q, a;
        longint max_step, step, room, t, span;
        write_count(raw);
        n        = table_count;
        shape    = $urandom_range(0, 5);
        max_step = 64'd4294967295 / n;
        case ($urandom_range(0, 3))
            0:       step = $urandom_range(1, 16);
            1:       step = 65536;
            2:       step = max_step;
            default: step = $urandom_range(1, int'(max_step));
        endcase
        if (step > max_step) step = max_step;
        room     = 64'd4294967295 - n * step;
        gen_x[1] = X_MIN + (room * $urandom_range(0, 1000)) / 1000;
        for (i = 2; i <= n; i++) begin
            if (shape == 2 && $urandom_range(0, 3) == 0) gen_x[i] = gen_x[i-1];
            else gen_x[i] = gen_x[i-1] + $urandom_range(1, int'(step));
        end
        if (shape == 3) begin
            gen_x[1] = X_MIN;
            gen_x[n] = X_MAX;
        end
        // flip into a descending table
        if (shape == 1 || (shape == 3 && $urandom_range(0, 1) == 1)) begin
            for (i = 1; i <= n / 2; i++) begin
                t            = gen_x[i];
                gen_x[i]     = gen_x[n+1-i];
                gen_x[n+1-i] = t;
            end
        end
        a = $urandom_range(0, 31);
        for (i = 1; i <= n; i++) begin
            if (shape == 5) gen_x[i] = longint'($signed($urandom));
            gen_y[i] = longint'($signed($urandom)) >>> a;
        end
        for (i = 1; i <= n; i++) begin
            if ($urandom_range(0, 19) == 0)
                push_load(($urandom_range(0, 1) == 0) ? 0 : $urandom_range(DEPTH + 1, 2047),
                          $signed($urandom), $signed($urandom));
            push_load(i, gen_x[i], gen_y[i]);
        end
        for (q = 0; q < n_queries; q++) begin
            i = $urandom_range(1, n - 1);
            case ($urandom_range(0, 9))
                0, 1, 2, 3, 4: begin
                    span = gen_x[i+1] - gen_x[i];
                    t    = gen_x[i] + (span * $urandom_range(0, 1000)) / 1000;
                end
                5:       t = gen_x[i];
                6:       t = ($urandom_range(0, 1) == 0) ? gen_x[1] - 1 : gen_x[n] + 1;
                7:       t = longint'($signed($urandom));
                8:       t = ($urandom_range(0, 1) == 0) ? X_MIN : X_MAX;
                default: t = gen_x[i] + (($urandom_range(0, 1) == 0) ? -1 : 1);
            endcase
            if (t < X_MIN) t = X_MIN;
            if (t > X_MAX) t = X_MAX;
            case ($urandom_range(0, 5))
                0:       push_query(t, 0);
                1:       push_query(t, $urandom_range(n + 1, 2047));
                default: push_query(t, $urandom_range(1, n));
            endcase
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Directed: small even-spaced table at the reset count
        push_load(1, 0, 65536);
        push_load(2, 65536, -131072);
        push_load(3, 131072, 64'sh7FFF0000);
        push_load(4, 196608, 5);
        push_load(0, X_MAX, X_MIN);
        push_load(DEPTH + 1, -1, -1);
        push_load(2047, -1, -1);
        push_load(DEPTH, X_MIN, X_MAX);
        push_query(98304, 2);
        push_query(65536, 0);
        push_query(X_MIN, 2047);
        push_query(X_MAX, 4);
        push_query(163840, 1);
        push_query(-5, 3);

        // Directed: full-span abscissae with a repeated node, extreme ordinates
        write_count(3);
        push_load(1, X_MIN, X_MAX);
        push_load(2, 0, X_MIN);
        push_load(3, 0, X_MAX);
        push_load(4, X_MAX, X_MIN);
        push_query(X_MAX, 4);
        push_query(0, 2);
        push_query(74565, 0);
        push_query(X_MIN, 1);

        // Random: the largest table once, then mostly small ones
        run_phase(2047, 15);
        while (items_queued < 1650) begin
            if ($urandom_range(0, 9) == 0) run_phase($urandom_range(0, 3), $urandom_range(10, 40));
            else run_phase($urandom_range(4, 24), $urandom_range(10, 40));
        end
        drain();
        repeat (100) @(posedge aclk);

        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

    // Watchdog
    initial begin
        #(20_000_000);
        $display("Some tests failed");
        $finish;
    end

endmodule
